// ===== rtl/rpge_pkg.sv =====
// ----------------------------------------------------------------------------
// rpge_pkg
// Shared types and constants for the reference-counted slot pool.
// ----------------------------------------------------------------------------
package rpge_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int KEY_BITS  = 64;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int TIME_W    = 32;
    localparam int REFS_W    = 16;
    localparam int GRACE_W   = 16;
    localparam int MAXS_W    = 5;

    localparam logic [1:0] MODE_ACQUIRE = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    localparam logic [2:0] ST_SHARED   = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_REFUSED  = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;
    localparam logic [2:0] ST_TICK     = 3'd5;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    // partial scan result handed from cell to cell
    typedef struct packed {
        logic                vld;
        logic                hit;
        logic [SLOT_W-1:0]   hit_idx;
        logic [REFS_W-1:0]   hit_refs;
        logic [CNT_W-1:0]    open_cnt;
        logic                best_vld;
        logic [SLOT_W-1:0]   best_idx;
        logic [TIME_W-1:0]   best_age;
        logic                free_vld;
        logic [SLOT_W-1:0]   free_idx;
        logic [CNT_W-1:0]    swept;
    } probe_t;

    // per-item context seen by every cell during a scan
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                sweep;
        logic [TIME_W-1:0]   now;
        logic [GRACE_W-1:0]  grace;
    } bcast_t;

    // slot update issued at the end of an item
    typedef struct packed {
        logic                evict_en;
        logic [SLOT_W-1:0]   evict_idx;
        logic                wr_en;
        logic                wr_new;
        logic [SLOT_W-1:0]   wr_idx;
        logic [REFS_W-1:0]   wr_refs;
        logic                wr_stamp;
    } upd_t;

endpackage

// ===== rtl/rpge_cell.sv =====
// ----------------------------------------------------------------------------
// rpge_cell
// One pool slot: holds its key, count and release time, folds itself into
// the passing probe and applies updates addressed to it.
// ----------------------------------------------------------------------------
module rpge_cell
    import rpge_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SLOT_W-1:0] my_idx,
    input  bcast_t            bc,
    input  upd_t              upd,
    input  probe_t            probe_in,
    output probe_t            probe_out
);

    logic                valid_reg, valid_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [REFS_W-1:0]   refs_reg, refs_next;
    logic [TIME_W-1:0]   rel_reg, rel_next;
    probe_t              probe_reg, probe_next;
    logic [TIME_W-1:0]   age;
    logic                idle;

    assign age       = bc.now - rel_reg;
    assign idle      = valid_reg && (refs_reg == '0);
    assign probe_out = probe_reg;

    always_comb begin
        probe_next = probe_in;
        valid_next = valid_reg;
        key_next   = key_reg;
        refs_next  = refs_reg;
        rel_next   = rel_reg;
        if (probe_in.vld) begin
            if (valid_reg && key_reg == bc.key && !probe_in.hit) begin
                probe_next.hit      = 1'b1;
                probe_next.hit_idx  = my_idx;
                probe_next.hit_refs = refs_reg;
            end
            if (valid_reg) begin
                probe_next.open_cnt = probe_in.open_cnt + CNT_W'(1);
            end
            if (idle && (!probe_in.best_vld || age > probe_in.best_age)) begin
                probe_next.best_vld = 1'b1;
                probe_next.best_idx = my_idx;
                probe_next.best_age = age;
            end
            if (!valid_reg && !probe_in.free_vld) begin
                probe_next.free_vld = 1'b1;
                probe_next.free_idx = my_idx;
            end
            if (bc.sweep && idle && age >= TIME_W'(bc.grace)) begin
                probe_next.swept = probe_in.swept + CNT_W'(1);
                valid_next       = 1'b0;
            end
        end
        if (upd.evict_en && upd.evict_idx == my_idx) begin
            valid_next = 1'b0;
            refs_next  = '0;
        end
        if (upd.wr_en && upd.wr_idx == my_idx) begin
            refs_next = upd.wr_refs;
            if (upd.wr_new) begin
                valid_next = 1'b1;
                key_next   = bc.key;
                rel_next   = '0;
            end else if (upd.wr_stamp) begin
                rel_next = bc.now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            refs_reg  <= '0;
            rel_reg   <= '0;
            probe_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            refs_reg  <= refs_next;
            rel_reg   <= rel_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

// ===== rtl/refcounted_pool_grace_evict_unit.sv =====
// ----------------------------------------------------------------------------
// refcounted_pool_grace_evict_unit
// Pool of keyed, reference-counted slots with idle eviction and timed sweep.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request item per handshake (acquire, release or tick).
//   m_ channel: one result item per request; mode 3 gives no result.
//   APB port: max_slots at 0x0, grace_ms at 0x4; write only while idle.
// Operation:
//   An accepted acquire, release or tick item launches a probe through a
//   row of NUM_SLOTS slot cells, one cell per cycle; the probe gathers key
//   match, open count, oldest idle slot, lowest free slot and sweep count.
//   The completed probe is registered; once the output register is free,
//   the slot update is applied and the result is registered. A new item is
//   taken only after the previous result has been registered.
// Reset:
//   All slots empty, counts and release times zero, clock zero, sweep
//   countdown 4000, max_slots 16, grace_ms 4000.
// Stalls:
//   A finished result waits in the output register; the next item is
//   accepted meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
module refcounted_pool_grace_evict_unit
    import rpge_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: mode[1:0], key[65:2], zero pad[71:66]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    // m_tdata: status[2:0], slot[6:3], evicted[7], ref_count[23:8],
    //          swept_count[28:24], zero pad[31:29]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ADDR_MAX_SLOTS = 3'h0;
    localparam logic [2:0] ADDR_GRACE     = 3'h4;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [MAXS_W-1:0]   max_slots_reg;
    logic [GRACE_W-1:0]  grace_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [GRACE_W-1:0]  cd_reg;
    logic                launch_reg;
    logic                sweep_reg;
    logic [1:0]          mode_reg;
    logic [KEY_BITS-1:0] key_reg;
    probe_t              res_reg;
    logic                m_valid_reg;
    logic [31:0]         m_data_reg;

    probe_t              probes [NUM_SLOTS+1];
    bcast_t              bc;
    upd_t                upd;

    logic                in_acc, out_free, finish;
    logic [1:0]          in_mode;
    logic [CNT_W-1:0]    limit;
    logic                full;
    logic [SLOT_W-1:0]   new_idx;
    logic [2:0]          r_status;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_evicted;
    logic [REFS_W-1:0]   r_refs;
    logic [CNT_W-1:0]    r_swept;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_mode  = s_tdata[1:0];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign finish   = (state_reg == S_DONE) && out_free;

    always_comb begin
        unique case (paddr)
            ADDR_MAX_SLOTS: prdata = {{(32-MAXS_W){1'b0}}, max_slots_reg};
            ADDR_GRACE:     prdata = {{(32-GRACE_W){1'b0}}, grace_reg};
            default:        prdata = '0;
        endcase
    end

    assign bc.key   = key_reg;
    assign bc.sweep = sweep_reg;
    assign bc.now   = now_reg;
    assign bc.grace = grace_reg;

    always_comb begin
        probes[0]     = '0;
        probes[0].vld = launch_reg;
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        rpge_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .my_idx    (SLOT_W'(g)),
            .bc        (bc),
            .upd       (upd),
            .probe_in  (probes[g]),
            .probe_out (probes[g+1])
        );
    end

    // result decision from the completed probe
    always_comb begin
        if (max_slots_reg == '0) begin
            limit = CNT_W'(1);
        end else if (int'(max_slots_reg) > NUM_SLOTS) begin
            limit = CNT_W'(NUM_SLOTS);
        end else begin
            limit = CNT_W'(max_slots_reg);
        end
        full    = res_reg.open_cnt >= limit;
        new_idx = (res_reg.free_vld && (!full || res_reg.free_idx < res_reg.best_idx))
                  ? res_reg.free_idx : res_reg.best_idx;

        upd       = '0;
        r_status  = ST_TICK;
        r_slot    = '0;
        r_evicted = 1'b0;
        r_refs    = '0;
        r_swept   = '0;
        unique case (mode_reg)
            MODE_ACQUIRE: begin
                if (res_reg.hit) begin
                    r_status    = ST_SHARED;
                    r_slot      = res_reg.hit_idx;
                    r_refs      = (res_reg.hit_refs == REFS_MAX) ? REFS_MAX
                                  : res_reg.hit_refs + REFS_W'(1);
                    upd.wr_en   = 1'b1;
                    upd.wr_idx  = res_reg.hit_idx;
                    upd.wr_refs = r_refs;
                end else if ((full && !res_reg.best_vld) ||
                             (!full && !res_reg.free_vld)) begin
                    r_status = ST_REFUSED;
                end else begin
                    r_status      = ST_NEW;
                    r_slot        = new_idx;
                    r_evicted     = full;
                    r_refs        = REFS_W'(1);
                    upd.evict_en  = full;
                    upd.evict_idx = res_reg.best_idx;
                    upd.wr_en     = 1'b1;
                    upd.wr_new    = 1'b1;
                    upd.wr_idx    = new_idx;
                    upd.wr_refs   = REFS_W'(1);
                end
            end
            MODE_RELEASE: begin
                if (res_reg.hit) begin
                    r_status     = ST_RELEASED;
                    r_slot       = res_reg.hit_idx;
                    r_refs       = (res_reg.hit_refs <= REFS_W'(1)) ? '0
                                   : res_reg.hit_refs - REFS_W'(1);
                    upd.wr_en    = 1'b1;
                    upd.wr_idx   = res_reg.hit_idx;
                    upd.wr_refs  = r_refs;
                    upd.wr_stamp = (res_reg.hit_refs <= REFS_W'(1));
                end else begin
                    r_status = ST_UNKNOWN;
                end
            end
            default: begin
                r_status = ST_TICK;
                r_swept  = res_reg.swept;
            end
        endcase
        upd.evict_en = upd.evict_en && finish;
        upd.wr_en    = upd.wr_en && finish;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_acc && in_mode != MODE_NONE) state_next = S_SCAN;
            S_SCAN: if (probes[NUM_SLOTS].vld) state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            max_slots_reg <= MAXS_W'(NUM_SLOTS);
            grace_reg     <= GRACE_W'(4000);
            now_reg       <= '0;
            cd_reg        <= GRACE_W'(4000);
            launch_reg    <= 1'b0;
            sweep_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= in_acc && in_mode != MODE_NONE;
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_MAX_SLOTS) max_slots_reg <= pwdata[MAXS_W-1:0];
                if (paddr == ADDR_GRACE) grace_reg <= pwdata[GRACE_W-1:0];
            end
            if (in_acc) begin
                sweep_reg <= 1'b0;
                if (in_mode == MODE_TICK) begin
                    now_reg <= now_reg + TIME_W'(1);
                    if (cd_reg <= GRACE_W'(1)) begin
                        sweep_reg <= 1'b1;
                        cd_reg    <= grace_reg;
                    end else begin
                        cd_reg <= cd_reg - GRACE_W'(1);
                    end
                end
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            mode_reg <= in_mode;
            key_reg  <= s_tdata[2 +: KEY_BITS];
        end
        if (state_reg == S_SCAN && probes[NUM_SLOTS].vld) begin
            res_reg <= probes[NUM_SLOTS];
        end
        if (finish) begin
            m_data_reg <= {3'b000, 5'(r_swept), r_refs, r_evicted, 4'(r_slot), r_status};
        end
    end

endmodule

// ===== sim/refcounted_pool_grace_evict_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_pool_grace_evict_unit_tb
// Self-checking bench for the reference-counted slot pool. A scoreboard
// tracks its own copy of the pool (slots, counts, release stamps, clock and
// sweep countdown) and predicts one result per non-mode-3 item; results from
// the m_ channel are compared field by field. Directed items cover shared
// and new acquires, idle release, unknown release, limit eviction with ties,
// refusal and out-of-range limits. The clock is then run up to the first
// sweep, random segments follow under changing limits and grace times with
// random stalls on both sides, and a final run drives one count to saturation.
// ----------------------------------------------------------------------------
module refcounted_pool_grace_evict_unit_tb;
    import rpge_pkg::*;

    localparam logic [1:0] MODE_UNUSED      = 2'd3;
    localparam logic [2:0] REG_MAX_SLOTS    = 3'h0;
    localparam logic [2:0] REG_GRACE_MS     = 3'h4;
    localparam int         MAX_SLOTS_RESET  = 16;
    localparam int         GRACE_RESET      = 4000;
    localparam int         STALL_LIMIT      = 2000;
    localparam int         SEGMENTS         = 16;
    localparam int         SEGMENT_ITEMS    = 100;
    localparam int         DRAIN_CYCLES     = NUM_SLOTS + 8;

    localparam logic [KEY_BITS-1:0] KEY_ZERO  = '0;
    localparam logic [KEY_BITS-1:0] KEY_ONES  = '1;
    localparam logic [KEY_BITS-1:0] KEY_ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [KEY_BITS-1:0] KEY_ALT_5 = 64'h5555_5555_5555_5555;
    localparam logic [KEY_BITS-1:0] KEY_MIX   = 64'h0123_4567_89AB_CDEF;

    typedef struct {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [REFS_W-1:0] ref_count;
        logic [4:0]        swept;
    } pool_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // mode[1:0], key[65:2], zero pad[71:66]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // status[2:0], slot[6:3], evicted[7],
                                  // ref_count[23:8], swept_count[28:24]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int src_idle     = 30;
    int snk_idle     = 83;
    int src_calm     = 0;
    int snk_calm     = 0;
    int stall_cycles = 0;

    int unsigned max_plan [SEGMENTS] =
        '{1, 0, 31, 16, 2, 3, 8, 4, 1, 5, 17, 2, 16, 3, 6, 15};
    int unsigned grace_plan [SEGMENTS] =
        '{1, 3, 8, 2, 5, 0, 12, 4, 40, 1, 6, 2, 20, 3, 7, 65535};

    class pool_scoreboard;
        logic [MAXS_W-1:0]   max_slots;
        logic [GRACE_W-1:0]  grace_ms;
        logic                valid [NUM_SLOTS];
        logic [KEY_BITS-1:0] keys [NUM_SLOTS];
        logic [REFS_W-1:0]   refs [NUM_SLOTS];
        logic [TIME_W-1:0]   released_at [NUM_SLOTS];
        logic [TIME_W-1:0]   now_ms;
        logic [GRACE_W-1:0]  countdown;
        pool_result_t        expected [$];
        int                  errors;

        function new();
            max_slots = MAXS_W'(MAX_SLOTS_RESET);
            grace_ms  = GRACE_W'(GRACE_RESET);
            countdown = GRACE_W'(GRACE_RESET);
            now_ms    = '0;
            errors    = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                valid[i]       = 1'b0;
                keys[i]        = '0;
                refs[i]        = '0;
                released_at[i] = '0;
            end
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 40)
                $display("%0t mismatch: %s", $time, what);
        endfunction

        function int find_key(logic [KEY_BITS-1:0] key);
            for (int i = 0; i < NUM_SLOTS; i++)
                if (valid[i] && keys[i] == key)
                    return i;
            return -1;
        endfunction

        function void note_request(logic [1:0] mode, logic [KEY_BITS-1:0] key);
            pool_result_t      r;
            int                idx;
            int                lim;
            int                open;
            int                best;
            logic [TIME_W-1:0] age;
            logic [TIME_W-1:0] best_age;
            r.status    = ST_TICK;
            r.slot      = '0;
            r.evicted   = 1'b0;
            r.ref_count = '0;
            r.swept     = '0;
            case (mode)
                MODE_ACQUIRE: begin
                    idx = find_key(key);
                    if (idx >= 0) begin
                        if (refs[idx] != REFS_MAX)
                            refs[idx]++;
                        r.status    = ST_SHARED;
                        r.slot      = SLOT_W'(idx);
                        r.ref_count = refs[idx];
                    end else begin
                        lim = (max_slots == 0) ? 1 :
                              (max_slots > NUM_SLOTS) ? NUM_SLOTS : int'(max_slots);
                        open = 0;
                        for (int i = 0; i < NUM_SLOTS; i++)
                            if (valid[i])
                                open++;
                        best     = -1;
                        best_age = '0;
                        if (open >= lim) begin
                            // oldest idle slot goes; ties keep the lowest index
                            for (int i = 0; i < NUM_SLOTS; i++) begin
                                if (valid[i] && refs[i] == 0) begin
                                    age = now_ms - released_at[i];
                                    if (best < 0 || age > best_age) begin
                                        best     = i;
                                        best_age = age;
                                    end
                                end
                            end
                            if (best >= 0) begin
                                valid[best] = 1'b0;
                                refs[best]  = '0;
                                r.evicted   = 1'b1;
                            end
                        end
                        idx = -1;
                        if (open < lim || best >= 0)
                            for (int i = 0; i < NUM_SLOTS; i++)
                                if (idx < 0 && !valid[i])
                                    idx = i;
                        if (idx < 0) begin
                            r.status = ST_REFUSED;
                        end else begin
                            valid[idx]       = 1'b1;
                            keys[idx]        = key;
                            refs[idx]        = REFS_W'(1);
                            released_at[idx] = '0;
                            r.status         = ST_NEW;
                            r.slot           = SLOT_W'(idx);
                            r.ref_count      = REFS_W'(1);
                        end
                    end
                end
                MODE_RELEASE: begin
                    idx = find_key(key);
                    if (idx < 0) begin
                        r.status = ST_UNKNOWN;
                    end else begin
                        if (refs[idx] <= 1) begin
                            refs[idx]        = '0;
                            released_at[idx] = now_ms;
                        end else begin
                            refs[idx]--;
                        end
                        r.status    = ST_RELEASED;
                        r.slot      = SLOT_W'(idx);
                        r.ref_count = refs[idx];
                    end
                end
                MODE_TICK: begin
                    now_ms++;
                    if (countdown <= 1) begin
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            age = now_ms - released_at[i];
                            if (valid[i] && refs[i] == 0 && age >= TIME_W'(grace_ms)) begin
                                valid[i] = 1'b0;
                                r.swept++;
                            end
                        end
                        countdown = grace_ms;
                    end else begin
                        countdown--;
                    end
                end
                default: return;
            endcase
            expected.push_back(r);
        endfunction

        function void check_result(logic [31:0] data);
            pool_result_t want;
            if (expected.size() == 0) begin
                report($sformatf("result %h with no request pending", data));
                return;
            end
            want = expected.pop_front();
            if (data[2:0] !== want.status)
                report($sformatf("status %0d, want %0d", data[2:0], want.status));
            if (data[6:3] !== want.slot)
                report($sformatf("slot %0d, want %0d", data[6:3], want.slot));
            if (data[7] !== want.evicted)
                report($sformatf("evicted %b, want %b", data[7], want.evicted));
            if (data[23:8] !== want.ref_count)
                report($sformatf("ref_count %0d, want %0d", data[23:8], want.ref_count));
            if (data[28:24] !== want.swept)
                report($sformatf("swept_count %0d, want %0d", data[28:24], want.swept));
        endfunction
    endclass

    pool_scoreboard sb;

    refcounted_pool_grace_evict_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (snk_calm > 0) begin
            snk_calm <= snk_calm - 1;
            m_tready <= 1'b1;
        end else if ($urandom_range(99) < 2) begin
            snk_calm <= $urandom_range(80, 10);
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("** refcounted_pool_grace_evict_unit: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(logic [1:0] mode, logic [KEY_BITS-1:0] key);
        if (src_calm > 0) begin
            src_calm--;
        end else if ($urandom_range(99) < 3) begin
            src_calm = $urandom_range(30, 8);
        end else if ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(2 * NUM_SLOTS + 6, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, key, mode};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(mode, key);
    endtask

    // wait out every pending result plus one full scan for an unanswered item
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == REG_MAX_SLOTS)
            sb.max_slots = value[MAXS_W-1:0];
        else
            sb.grace_ms = value[GRACE_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== value)
            sb.report($sformatf("register %0h reads %h, wrote %h", addr, prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // acquire/release traffic over a small key set, with ticks and noise
    task automatic run_segment(int count);
        logic [KEY_BITS-1:0] key_set [$];
        logic [KEY_BITS-1:0] k;
        logic [1:0]          mode;
        int                  n;
        int                  pick;
        int                  done;
        n = $urandom_range(24, 2);
        repeat (n) begin
            case ($urandom_range(3))
                0:       k = 64'd1 << $urandom_range(63);
                1:       k = ~(64'd1 << $urandom_range(63));
                2:       k = $urandom_range(1) ? KEY_ONES : KEY_ZERO;
                default: k = {$urandom, $urandom};
            endcase
            key_set.push_back(k);
        end
        done = 0;
        while (done < count) begin
            k    = key_set[$urandom_range(n - 1)];
            pick = $urandom_range(99);
            if (pick < 42) begin
                mode = MODE_ACQUIRE;
            end else if (pick < 74) begin
                mode = MODE_RELEASE;
            end else if (pick < 93) begin
                mode = MODE_TICK;
                k    = {$urandom, $urandom};
            end else if (pick < 98) begin
                mode = (pick < 96) ? MODE_RELEASE : MODE_ACQUIRE;
                k    = {$urandom, $urandom};
            end else begin
                mode = MODE_UNUSED;
            end
            send_item(mode, k);
            if (mode != MODE_UNUSED)
                done++;
        end
    endtask

    initial begin
        logic [KEY_BITS-1:0] sat_key;
        int                  sat_slot;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(MODE_ACQUIRE, KEY_ZERO);
        send_item(MODE_ACQUIRE, KEY_ONES);
        send_item(MODE_ACQUIRE, KEY_ZERO);
        send_item(MODE_RELEASE, KEY_ZERO);
        send_item(MODE_RELEASE, KEY_ZERO);
        send_item(MODE_RELEASE, KEY_ZERO);
        send_item(MODE_ACQUIRE, KEY_ZERO);
        send_item(MODE_RELEASE, KEY_ZERO);
        send_item(MODE_RELEASE, KEY_ALT_5);
        send_item(MODE_UNUSED, KEY_MIX);
        send_item(MODE_TICK, KEY_ONES);
        send_item(MODE_TICK, KEY_ZERO);
        send_item(MODE_ACQUIRE, KEY_ALT_A);
        send_item(MODE_RELEASE, KEY_ONES);
        settle();

        // limit below the open count, then a three-way age tie
        reg_write(REG_MAX_SLOTS, 32'd2);
        send_item(MODE_ACQUIRE, KEY_ALT_5);
        send_item(MODE_RELEASE, KEY_ALT_A);
        send_item(MODE_RELEASE, KEY_ALT_5);
        send_item(MODE_ACQUIRE, KEY_MIX);
        send_item(MODE_ACQUIRE, KEY_ALT_5);
        send_item(MODE_ACQUIRE, KEY_ONES);
        send_item(MODE_ACQUIRE, KEY_ZERO);
        settle();

        reg_write(REG_MAX_SLOTS, 32'd0);
        send_item(MODE_ACQUIRE, KEY_ALT_A);
        send_item(MODE_RELEASE, KEY_MIX);
        send_item(MODE_ACQUIRE, KEY_ALT_A);
        settle();

        // run the clock up to the first sweep with zero grace
        reg_write(REG_MAX_SLOTS, 32'd31);
        reg_write(REG_GRACE_MS, 32'd0);
        send_item(MODE_RELEASE, KEY_ONES);
        while (sb.countdown > 1)
            send_item(MODE_TICK, {$urandom, $urandom});
        repeat (3) send_item(MODE_TICK, {$urandom, $urandom});

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            if (seg == 6) begin
                src_idle = 83;
                snk_idle = 30;
            end else if (seg == 12) begin
                src_idle = 0;
                snk_idle = 0;
            end
            reg_write(REG_MAX_SLOTS, max_plan[seg]);
            reg_write(REG_GRACE_MS, grace_plan[seg]);
            run_segment(SEGMENT_ITEMS);
        end

        // drive one count into saturation
        settle();
        reg_write(REG_MAX_SLOTS, 32'd16);
        for (int i = 0; i < NUM_SLOTS; i++)
            while (sb.valid[i] && sb.refs[i] != 0)
                send_item(MODE_RELEASE, sb.keys[i]);
        sat_key = {$urandom, $urandom};
        send_item(MODE_ACQUIRE, sat_key);
        sat_slot = sb.find_key(sat_key);
        while (sb.refs[sat_slot] != REFS_MAX)
            send_item(MODE_ACQUIRE, sat_key);
        repeat (2) send_item(MODE_ACQUIRE, sat_key);
        send_item(MODE_RELEASE, sat_key);
        settle();

        if (sb.errors == 0)
            $display("** refcounted_pool_grace_evict_unit: PASSED **");
        else
            $display("** refcounted_pool_grace_evict_unit: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rpge_pkg.sv
rtl/rpge_cell.sv
rtl/refcounted_pool_grace_evict_unit.sv
sim/refcounted_pool_grace_evict_unit_tb.sv
